### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the segment converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSFC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSFC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/lsfc_pkg.sv
// ----------------------------------------------------------------------------
// lsfc_pkg
// Constants, the arctangent table and shared types of the segment converter.
// ----------------------------------------------------------------------------
package lsfc_pkg;

  localparam int unsigned ANGLE_WIDTH = 17;
  localparam int unsigned GUARD       = 8;
  localparam int unsigned ZW          = 26;
  localparam int unsigned ATAN_LEN    = 24;

  typedef logic signed [ZW-1:0] z_t;

  localparam logic [31:0] INV_GAIN    = 32'd2608131496;
  localparam z_t          DEG90_Z     = 26'sd5898240;
  localparam z_t          DEG180_Z    = 26'sd11796480;
  localparam int          ANGLE_LIMIT = 46080;

  typedef struct packed {
    logic cmd;
    logic flip;
    logic zero;
  } lsfc_ctrl_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic z_t atan_z(input int unsigned idx);
    z_t r;
    case (idx)
      0:  r = 26'sd2949120;
      1:  r = 26'sd1740967;
      2:  r = 26'sd919879;
      3:  r = 26'sd466945;
      4:  r = 26'sd234379;
      5:  r = 26'sd117304;
      6:  r = 26'sd58666;
      7:  r = 26'sd29335;
      8:  r = 26'sd14668;
      9:  r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      20: r = 26'sd4;
      21: r = 26'sd2;
      22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/line_segment_form_converter.sv
// ----------------------------------------------------------------------------
// line_segment_form_converter
// Converts a line segment between endpoint form and center/length/rotation
// form with a fully pipelined CORDIC.
// ----------------------------------------------------------------------------
// Input beats arrive on the s_axis group, results leave on the m_axis group.
// tuser on the input selects the direction: 0 takes two endpoints and returns
// midpoint, length and angle; 1 takes center, length and angle and returns
// the endpoints. tuser on the output carries the saturation flag.
// Every beat produces exactly one result beat, in order.
// One input stage, one register per CORDIC iteration and three output
// stages for gain compensation, rounding and saturation. A new beat is
// taken in every cycle while the output is not stalled, so throughput is
// one beat per clock.
// Reset empties the pipeline; no result is pending afterwards.
// When the receiver holds tready low while a result waits, the whole pipeline
// freezes and s_axis_tready drops until the result is taken; no beat is lost
// or repeated.
// ----------------------------------------------------------------------------
module line_segment_form_converter
  import lsfc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = 24,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // first_x, first_y, second_x, second_y, mid_x, mid_y, seg_length, angle_in
  input  logic [((7*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // cmd
  input  logic [0:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_first_x, out_first_y, out_second_x, out_second_y, out_mid_x,
  // out_mid_y, out_length, out_angle
  output logic [((7*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // length_saturated
  output logic [0:0]                   m_axis_tuser
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned CW = COORD_WIDTH + 12;
  localparam int unsigned EW = 7*COORD_WIDTH + ANGLE_WIDTH;
  localparam int unsigned DW = ((7*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8;
  localparam int unsigned N  = CORDIC_STAGES;

  logic                 en;
  logic                 vld   [N+1];
  lsfc_ctrl_t           ctrl  [N+1];
  logic signed [CW-1:0] cx    [N+1];
  logic signed [CW-1:0] cy    [N+1];
  z_t                   cz    [N+1];
  logic [EW-1:0]        echo  [N+1];
  logic [EW-1:0]        out_data;
  logic                 out_flag;
  logic                 out_valid;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  lsfc_pre #(.W(W), .CW(CW), .EW(EW)) u_pre (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid),
    .cmd_i        (s_axis_tuser[0]),
    .first_x_i    (s_axis_tdata[W-1:0]),
    .first_y_i    (s_axis_tdata[2*W-1:W]),
    .second_x_i   (s_axis_tdata[3*W-1:2*W]),
    .second_y_i   (s_axis_tdata[4*W-1:3*W]),
    .mid_x_i      (s_axis_tdata[5*W-1:4*W]),
    .mid_y_i      (s_axis_tdata[6*W-1:5*W]),
    .seg_length_i (s_axis_tdata[7*W-1:6*W]),
    .angle_i      (s_axis_tdata[EW-1:7*W]),
    .valid_o      (vld[0]),
    .ctrl_o       (ctrl[0]),
    .x_o          (cx[0]),
    .y_o          (cy[0]),
    .z_o          (cz[0]),
    .echo_o       (echo[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_stage
    lsfc_cordic_stage #(.CW(CW), .EW(EW), .IDX(i)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .ctrl_i  (ctrl[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .echo_i  (echo[i]),
      .valid_o (vld[i+1]),
      .ctrl_o  (ctrl[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1]),
      .echo_o  (echo[i+1])
    );
  end

  lsfc_post #(.W(W), .CW(CW), .EW(EW)) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld[N]),
    .ctrl_i  (ctrl[N]),
    .x_i     (cx[N]),
    .y_i     (cy[N]),
    .z_i     (cz[N]),
    .echo_i  (echo[N]),
    .valid_o (out_valid),
    .data_o  (out_data),
    .flag_o  (out_flag)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DW'(out_data);
  assign m_axis_tuser  = out_flag;

endmodule

### rtl/lsfc_pre.sv
// ----------------------------------------------------------------------------
// lsfc_pre
// Input stage: difference vector and midpoint, or scaled half length and
// quadrant-reduced angle, loaded into the first pipeline register.
// ----------------------------------------------------------------------------
module lsfc_pre
  import lsfc_pkg::*;
#(
  parameter int unsigned W  = 24,
  parameter int unsigned CW = 36,
  parameter int unsigned EW = 185
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic                          cmd_i,
  input  logic signed [W-1:0]           first_x_i,
  input  logic signed [W-1:0]           first_y_i,
  input  logic signed [W-1:0]           second_x_i,
  input  logic signed [W-1:0]           second_y_i,
  input  logic signed [W-1:0]           mid_x_i,
  input  logic signed [W-1:0]           mid_y_i,
  input  logic        [W-1:0]           seg_length_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  output logic                          valid_o,
  output lsfc_ctrl_t                    ctrl_o,
  output logic signed [CW-1:0]          x_o,
  output logic signed [CW-1:0]          y_o,
  output z_t                            z_o,
  output logic        [EW-1:0]          echo_o
);

  logic signed [W:0]    dx, dy, sx, sy;
  logic signed [CW-1:0] vx, vy;
  logic [W+31:0]        prod;
  z_t                   za;
  logic                 valid_q;
  lsfc_ctrl_t           ctrl_d, ctrl_q;
  logic signed [CW-1:0] x_d, x_q, y_d, y_q;
  z_t                   z_d, z_q;
  logic [EW-1:0]        echo_d, echo_q;

  always_comb begin
    dx   = {first_x_i[W-1], first_x_i} - {second_x_i[W-1], second_x_i};
    dy   = {first_y_i[W-1], first_y_i} - {second_y_i[W-1], second_y_i};
    sx   = {first_x_i[W-1], first_x_i} + {second_x_i[W-1], second_x_i};
    sy   = {first_y_i[W-1], first_y_i} + {second_y_i[W-1], second_y_i};
    vx   = CW'(dx) <<< GUARD;
    vy   = CW'(dy) <<< GUARD;
    prod = (W+32)'(seg_length_i) * (W+32)'(INV_GAIN);
    za   = ZW'(angle_i) <<< GUARD;

    ctrl_d.cmd  = cmd_i;
    ctrl_d.flip = 1'b0;
    ctrl_d.zero = (dx == '0) && (dy == '0);
    if (cmd_i) begin
      x_d = CW'(prod[W+31:32-GUARD+1]);
      y_d = '0;
      z_d = za;
      if (za > DEG90_Z) begin
        z_d         = za - DEG180_Z;
        ctrl_d.flip = 1'b1;
      end else if (za < -DEG90_Z) begin
        z_d         = za + DEG180_Z;
        ctrl_d.flip = 1'b1;
      end
      echo_d = {angle_i, seg_length_i, mid_y_i, mid_x_i, {(4*W){1'b0}}};
    end else begin
      if (dx < 0) begin
        x_d = -vx;
        y_d = -vy;
        z_d = (dy >= 0) ? DEG180_Z : -DEG180_Z;
      end else begin
        x_d = vx;
        y_d = vy;
        z_d = '0;
      end
      echo_d = {{(ANGLE_WIDTH + W){1'b0}}, sy[W:1], sx[W:1],
                second_y_i, second_x_i, first_y_i, first_x_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      echo_q <= echo_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign echo_o  = echo_q;

endmodule

### rtl/lsfc_cordic_stage.sv
// ----------------------------------------------------------------------------
// lsfc_cordic_stage
// One registered CORDIC micro-rotation, vectoring or rotation by command.
// ----------------------------------------------------------------------------
module lsfc_cordic_stage
  import lsfc_pkg::*;
#(
  parameter int unsigned CW  = 36,
  parameter int unsigned EW  = 185,
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  lsfc_ctrl_t           ctrl_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  z_t                   z_i,
  input  logic        [EW-1:0] echo_i,
  output logic                 valid_o,
  output lsfc_ctrl_t           ctrl_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output z_t                   z_o,
  output logic        [EW-1:0] echo_o
);

  logic signed [CW-1:0] xs, ys, x_d, x_q, y_d, y_q;
  z_t                   z_d, z_q;
  logic                 sel;
  logic                 valid_q;
  lsfc_ctrl_t           ctrl_q;
  logic [EW-1:0]        echo_q;

  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    sel = ctrl_i.cmd ? (z_i >= 0) : (y_i < 0);
    if (sel) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_z(IDX);
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_z(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      echo_q <= echo_i;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign echo_o  = echo_q;

endmodule

### rtl/lsfc_post.sv
// ----------------------------------------------------------------------------
// lsfc_post
// Output stages: gain compensation, rounding to port scale, angle clamp and
// endpoint saturation, ending in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsfc_post
  import lsfc_pkg::*;
#(
  parameter int unsigned W  = 24,
  parameter int unsigned CW = 36,
  parameter int unsigned EW = 185
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  lsfc_ctrl_t           ctrl_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  z_t                   z_i,
  input  logic        [EW-1:0] echo_i,
  output logic                 valid_o,
  output logic        [EW-1:0] data_o,
  output logic                 flag_o
);

  localparam int unsigned SW = CW + 1;

  // Stage A
  logic                 va_q;
  lsfc_ctrl_t           ca_q;
  logic [63:0]          ux, phi_q, plo_q;
  logic signed [CW-1:0] xa_q, ya_q;
  z_t                   za_q;
  logic [EW-1:0]        ea_q;
  // Stage B
  logic                 vb_q;
  lsfc_ctrl_t           cb_q;
  logic [63:0]          mag, lenr;
  logic [W-1:0]         lenb_d, lenb_q;
  logic                 big_d, big_q;
  z_t                   zr;
  logic signed [ZW-9:0] zs;
  logic signed [ANGLE_WIDTH-1:0] angb_d, angb_q;
  logic signed [CW-1:0] dxb_q, dyb_q;
  logic [EW-1:0]        eb_q;
  // Stage C
  logic                 vc_q;
  logic [EW-1:0]        data_d, data_q;
  logic                 flag_d, flag_q;
  logic [W:0]           c0, c1, c2, c3;

  function automatic logic [W:0] clip(input logic signed [W-1:0] base,
                                      input logic signed [CW-1:0] delta,
                                      input logic sub);
    logic signed [SW-1:0] s;
    logic [W:0]           r;
    s = sub ? (SW'(base) - SW'(delta)) : (SW'(base) + SW'(delta));
    if ((s[SW-1:W-1] == '0) || (s[SW-1:W-1] == '1)) begin
      r = {1'b0, s[W-1:0]};
    end else begin
      r = {1'b1, s[SW-1], {(W-1){~s[SW-1]}}};
    end
    return r;
  endfunction

  always_comb begin
    ux = (x_i > 0) ? {{(64-CW){1'b0}}, x_i} : 64'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q  <= ctrl_i;
      phi_q <= 64'(ux[63:32]) * 64'(INV_GAIN);
      plo_q <= 64'(ux[31:0]) * 64'(INV_GAIN);
      xa_q  <= ctrl_i.flip ? -x_i : x_i;
      ya_q  <= ctrl_i.flip ? -y_i : y_i;
      za_q  <= z_i;
      ea_q  <= echo_i;
    end
  end

  always_comb begin
    mag    = phi_q + (plo_q >> 32);
    lenr   = (mag + 64'd128) >> GUARD;
    big_d  = (lenr >> W) != 64'd0;
    lenb_d = lenr[W-1:0];
    zr     = za_q + z_t'(128);
    zs     = zr[ZW-1:GUARD];
    if (zs > ANGLE_LIMIT) begin
      angb_d = ANGLE_WIDTH'(ANGLE_LIMIT);
    end else if (zs < -ANGLE_LIMIT) begin
      angb_d = -ANGLE_WIDTH'(ANGLE_LIMIT);
    end else begin
      angb_d = zs[ANGLE_WIDTH-1:0];
    end
    if (ca_q.zero) begin
      big_d  = 1'b0;
      lenb_d = '0;
      angb_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cb_q   <= ca_q;
      lenb_q <= lenb_d;
      big_q  <= big_d;
      angb_q <= angb_d;
      dxb_q  <= (xa_q + CW'(128)) >>> GUARD;
      dyb_q  <= (ya_q + CW'(128)) >>> GUARD;
      eb_q   <= ea_q;
    end
  end

  always_comb begin
    c0 = clip(eb_q[5*W-1:4*W], dxb_q, 1'b0);
    c1 = clip(eb_q[6*W-1:5*W], dyb_q, 1'b0);
    c2 = clip(eb_q[5*W-1:4*W], dxb_q, 1'b1);
    c3 = clip(eb_q[6*W-1:5*W], dyb_q, 1'b1);
    if (cb_q.cmd) begin
      data_d = {eb_q[EW-1:4*W], c3[W-1:0], c2[W-1:0], c1[W-1:0], c0[W-1:0]};
      flag_d = c0[W] | c1[W] | c2[W] | c3[W];
    end else begin
      data_d = {angb_q, big_q ? {W{1'b1}} : lenb_q, eb_q[6*W-1:0]};
      flag_d = big_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign valid_o = vc_q;
  assign data_o  = data_q;
  assign flag_o  = flag_q;

  `LSFC_ASSERT_IMP(a_len_sat_max, clk_i, rst_ni,
                   vb_q && !cb_q.cmd && big_q && en_i,
                   data_d[7*W-1:6*W] == '1)
  `LSFC_ASSERT_IMP(a_ang_range, clk_i, rst_ni, vb_q && !cb_q.cmd,
                   (angb_q <= ANGLE_LIMIT) && (angb_q >= -ANGLE_LIMIT))
  `LSFC_ASSERT_NXT(a_zero_vec, clk_i, rst_ni,
                   va_q && en_i && !ca_q.cmd && ca_q.zero,
                   (lenb_q == '0) && (angb_q == '0) && !big_q)

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Segment converter testbench
// Drives random and directed segment beats in both directions with random
// idling on both sides, predicts every result with a bit-accurate CORDIC
// model and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module tb
  import lsfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 24;
  localparam int DW = ((7*CW+ANGLE_WIDTH+7)/8)*8;
  localparam int STAGES = 16;
  localparam logic CMD_TO_CENTER = 1'b0;
  localparam logic CMD_TO_ENDS = 1'b1;

  typedef struct {
    logic [DW-1:0] data;
    logic          user;
  } seg_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  seg_beat_t pending_q[$];
  seg_beat_t conv_expect_q[$];
  int  fails = 0;
  bit  stim_done = 1'b0;
  bit  calm = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_cycles = 0;
  int  angs[10] = '{0, 46080, -46080, 23040, -23040, 65535, -65536, 11520, 23041, -23041};
  string names[9] = '{"out_first_x", "out_first_y", "out_second_x", "out_second_y",
                      "out_mid_x", "out_mid_y", "out_length", "out_angle",
                      "length_saturated"};

  line_segment_form_converter dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_tab(int i);
    longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint clip_coord(longint v, ref bit flag);
    longint hi;
    hi = (64'sd1 <<< (CW-1)) - 1;
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < -hi-1) begin
      flag = 1'b1;
      return -hi-1;
    end
    return v;
  endfunction

  function automatic seg_beat_t convert_segment(seg_beat_t in);
    seg_beat_t r;
    longint x1, y1, x2, y2, mx, my, dx, dy, x, y, z, xs, ys, ang, ox, oy;
    logic [63:0] ux, mag, len;
    bit flag, flip;
    flag = 1'b0;
    flip = 1'b0;
    x1 = longint'($signed(in.data[0*CW +: CW]));
    y1 = longint'($signed(in.data[1*CW +: CW]));
    x2 = longint'($signed(in.data[2*CW +: CW]));
    y2 = longint'($signed(in.data[3*CW +: CW]));
    mx = longint'($signed(in.data[4*CW +: CW]));
    my = longint'($signed(in.data[5*CW +: CW]));
    len = 64'(in.data[6*CW +: CW]);
    ang = longint'($signed(in.data[7*CW +: ANGLE_WIDTH]));
    r.data = '0;
    if (in.user == CMD_TO_CENTER) begin
      dx = x1 - x2;
      dy = y1 - y2;
      if (dx == 0 && dy == 0) begin
        len = 0;
        ang = 0;
      end else begin
        x = dx <<< GUARD;
        y = dy <<< GUARD;
        z = 0;
        if (x < 0) begin
          z = (y >= 0) ? 11796480 : -11796480;
          x = -x;
          y = -y;
        end
        for (int i = 0; i < STAGES; i++) begin
          xs = shr_floor(x, i);
          ys = shr_floor(y, i);
          if (y < 0) begin
            x -= ys; y += xs; z -= atan_tab(i);
          end else begin
            x += ys; y -= xs; z += atan_tab(i);
          end
        end
        ux = (x > 0) ? 64'(x) : 64'd0;
        mag = (ux >> 32) * 64'(INV_GAIN) + (((ux & 64'hFFFFFFFF) * 64'(INV_GAIN)) >> 32);
        len = (mag + 64'd128) >> GUARD;
        ang = shr_floor(z + 128, GUARD);
      end
      if (len > 64'hFFFFFF) begin
        len = 64'hFFFFFF;
        flag = 1'b1;
      end
      if (ang > ANGLE_LIMIT) ang = ANGLE_LIMIT;
      if (ang < -ANGLE_LIMIT) ang = -ANGLE_LIMIT;
      r.data[0*CW +: 4*CW] = in.data[0*CW +: 4*CW];
      r.data[4*CW +: CW] = CW'(shr_floor(x1 + x2, 1));
      r.data[5*CW +: CW] = CW'(shr_floor(y1 + y2, 1));
      r.data[6*CW +: CW] = CW'(len);
      r.data[7*CW +: ANGLE_WIDTH] = ANGLE_WIDTH'(ang);
    end else begin
      z = ang * 256;
      if (z > 5898240) begin
        z -= 11796480; flip = 1'b1;
      end else if (z < -5898240) begin
        z += 11796480; flip = 1'b1;
      end
      x = longint'((len * 64'(INV_GAIN)) >> 25);
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
        xs = shr_floor(x, i);
        ys = shr_floor(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab(i);
        end else begin
          x += ys; y -= xs; z += atan_tab(i);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      ox = shr_floor(x + 128, GUARD);
      oy = shr_floor(y + 128, GUARD);
      r.data[0*CW +: CW] = CW'(clip_coord(mx + ox, flag));
      r.data[1*CW +: CW] = CW'(clip_coord(my + oy, flag));
      r.data[2*CW +: CW] = CW'(clip_coord(mx - ox, flag));
      r.data[3*CW +: CW] = CW'(clip_coord(my - oy, flag));
      r.data[4*CW +: 4*CW-CW] = in.data[4*CW +: 3*CW];
      r.data[7*CW +: ANGLE_WIDTH] = in.data[7*CW +: ANGLE_WIDTH];
    end
    r.user = flag;
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 4000)) - 2000);
      2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return CW'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  task automatic add_item(logic cmd, logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                          logic [CW-1:0] d, logic [CW-1:0] e, logic [CW-1:0] f,
                          logic [CW-1:0] l, logic [ANGLE_WIDTH-1:0] g);
    seg_beat_t it;
    it.data = '0;
    it.data[0 +: 7*CW] = {l, f, e, d, c, b, a};
    it.data[7*CW +: ANGLE_WIDTH] = g;
    it.user = cmd;
    pending_q.push_back(it);
  endtask

  initial begin
    logic [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    add_item(CMD_TO_CENTER, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(CMD_TO_CENTER, 100, 200, 100, 200, 0, 0, 0, 0);
    add_item(CMD_TO_CENTER, mx, mx, mn, mn, mx, mn, '1, '1);
    add_item(CMD_TO_CENTER, mn, mn, mx, mx, 0, 0, 0, 0);
    add_item(CMD_TO_CENTER, mn, 0, mx, 0, 0, 0, 0, 0);
    add_item(CMD_TO_CENTER, mn, 24'hFFFFFF, mx, 0, 0, 0, 0, 0);
    add_item(CMD_TO_CENTER, mn, 1, mx, 0, 0, 0, 0, 0);
    add_item(CMD_TO_CENTER, 0, mx, 0, mn, 0, 0, 0, 0);
    add_item(CMD_TO_CENTER, 24'hFFFFFF, 1, 0, 0, 0, 0, 0, 0);
    add_item(CMD_TO_ENDS, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(CMD_TO_ENDS, 0, 0, 0, 0, mx, mx, '1, 0);
    add_item(CMD_TO_ENDS, 0, 0, 0, 0, mn, mn, '1, 17'(-23040));
    add_item(CMD_TO_ENDS, mx, mx, mx, mx, 0, 0, 24'd256, '1);
    foreach (angs[i])
      add_item(CMD_TO_ENDS, 0, 0, 0, 0, rand_coord(3), rand_coord(3),
               $urandom_range(0, 1) ? '1 : 24'd51200, ANGLE_WIDTH'(angs[i]));
    for (int n = 0; n < 950; n++) begin
      if ($urandom_range(0, 1))
        add_item(CMD_TO_CENTER, rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                 rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                 CW'($urandom), CW'($urandom), CW'($urandom), ANGLE_WIDTH'($urandom));
      else
        add_item(CMD_TO_ENDS, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                 rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                 $urandom_range(0, 3) == 0 ? CW'($urandom) : CW'($urandom_range(0, 400000)),
                 $urandom_range(0, 7) == 0 ? ANGLE_WIDTH'($urandom)
                                           : ANGLE_WIDTH'($urandom_range(0, 92160) - 46080));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && conv_expect_q.size() == 0);
    repeat (STAGES + 20) @(posedge clk_i);
    if (fails == 0 && conv_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

  // Driver: one queued beat per handshake, with random gaps until the last part.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      calm <= pending_q.size() < 120;
      if (s_axis_tvalid && s_axis_tready) begin
        conv_expect_q.push_back(convert_segment('{s_axis_tdata, s_axis_tuser[0]}));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 7);
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_axis_tdata <= pending_q[0].data;
          s_axis_tuser <= pending_q[0].user;
          pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Receiver readiness, including one long hold-off early in the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 200 && hold_cycles < 300) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare every result beat with the oldest prediction.
  always @(posedge clk_i) begin
    seg_beat_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (conv_expect_q.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        exp_b = conv_expect_q.pop_front();
        for (int f = 0; f < 7; f++)
          if (m_axis_tdata[f*CW +: CW] !== exp_b.data[f*CW +: CW]) begin
            $error("%s expected %h actual %h", names[f], exp_b.data[f*CW +: CW],
                   m_axis_tdata[f*CW +: CW]);
            fails++;
          end
        if (m_axis_tdata[7*CW +: ANGLE_WIDTH] !== exp_b.data[7*CW +: ANGLE_WIDTH]) begin
          $error("%s expected %h actual %h", names[7], exp_b.data[7*CW +: ANGLE_WIDTH],
                 m_axis_tdata[7*CW +: ANGLE_WIDTH]);
          fails++;
        end
        if (m_axis_tuser[0] !== exp_b.user) begin
          $error("%s expected %b actual %b", names[8], exp_b.user, m_axis_tuser[0]);
          fails++;
        end
      end
    end
  end
endmodule

### files.f
+incdir+rtl
rtl/lsfc_pkg.sv
rtl/lsfc_pre.sv
rtl/lsfc_cordic_stage.sv
rtl/lsfc_post.sv
rtl/line_segment_form_converter.sv
tb/tb.sv
